>>> design/fme_pkg.sv
// ----------------------------------------------------------------------------
// Fuzzy membership package
// Shape codes, register indexes and the control word that travels down
// the divider chain.
// ----------------------------------------------------------------------------
package fme_pkg;

  localparam logic [1:0] SHAPE_LEFT_SHOULDER  = 2'd0;
  localparam logic [1:0] SHAPE_RIGHT_SHOULDER = 2'd1;
  localparam logic [1:0] SHAPE_TRIANGLE       = 2'd2;
  localparam logic [1:0] SHAPE_TRAPEZOID      = 2'd3;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SHAPE_MODE   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FIRST_POINT  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SECOND_POINT = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_THIRD_POINT  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LAST_POINT   = 3'd4;

  // valid: the stage holds a request.
  // flat:  the degree is settled without the ramp division.
  // full:  with flat set, the degree is full membership, otherwise zero.
  typedef struct packed {
    logic valid;
    logic flat;
    logic full;
  } stage_ctl_t;

endpackage

>>> design/fme_front.sv
// ----------------------------------------------------------------------------
// Fuzzy membership front stage
// Classifies the crisp value against the breakpoints and registers either a
// flat degree or the ramp distance and width for the divider chain.
// ----------------------------------------------------------------------------
module fme_front #(
  parameter int VALUE_WIDTH   = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_take,
  input  logic signed [VALUE_WIDTH-1:0] crisp,
  input  logic [1:0]                    shape_mode,
  input  logic signed [VALUE_WIDTH-1:0] first_point,
  input  logic signed [VALUE_WIDTH-1:0] second_point,
  input  logic signed [VALUE_WIDTH-1:0] third_point,
  input  logic signed [VALUE_WIDTH-1:0] last_point,
  output fme_pkg::stage_ctl_t           ctl_o,
  output logic [VALUE_WIDTH-1:0]        rem_o,
  output logic [VALUE_WIDTH-1:0]        width_o,
  output logic [FRACTION_BITS-1:0]      quo_o
);
  import fme_pkg::*;

  logic signed [VALUE_WIDTH:0] xe, se, pe, qe, ee;
  logic signed [VALUE_WIDTH:0] ramp_dist, span;
  logic                        flat, full;
  stage_ctl_t                  ctl_r, ctl_nxt;
  logic [VALUE_WIDTH-1:0]      rem_r, width_r;

  assign xe = {crisp[VALUE_WIDTH-1], crisp};
  assign se = {first_point[VALUE_WIDTH-1], first_point};
  assign pe = {second_point[VALUE_WIDTH-1], second_point};
  assign qe = {third_point[VALUE_WIDTH-1], third_point};
  assign ee = {last_point[VALUE_WIDTH-1], last_point};

  always_comb begin
    flat      = 1'b0;
    full      = 1'b0;
    ramp_dist = xe - se;
    span      = ee - se;
    case (shape_mode)
      SHAPE_LEFT_SHOULDER: begin
        ramp_dist = ee - xe;
        if (crisp <= first_point) begin
          flat = 1'b1;
          full = 1'b1;
        end else if (crisp >= last_point) begin
          flat = 1'b1;
        end
      end
      SHAPE_RIGHT_SHOULDER: begin
        if (crisp <= first_point) begin
          flat = 1'b1;
        end else if (crisp >= last_point) begin
          flat = 1'b1;
          full = 1'b1;
        end
      end
      SHAPE_TRIANGLE: begin
        if (crisp <= first_point || crisp >= last_point) begin
          flat = 1'b1;
        end else if (crisp == second_point) begin
          flat = 1'b1;
          full = 1'b1;
        end else if (crisp < second_point) begin
          span = pe - se;
        end else begin
          ramp_dist = ee - xe;
          span      = ee - pe;
        end
      end
      default: begin
        if (crisp <= first_point || crisp >= last_point) begin
          flat = 1'b1;
        end else if (crisp >= second_point && crisp <= third_point) begin
          flat = 1'b1;
          full = 1'b1;
        end else if (crisp < second_point) begin
          span = pe - se;
        end else begin
          ramp_dist = ee - xe;
          span      = ee - qe;
        end
      end
    endcase

    // A ramp with no positive width or distance gives zero; a distance at or
    // beyond the width saturates to full membership.
    if (!flat) begin
      if (span <= 0 || ramp_dist <= 0) begin
        flat = 1'b1;
        full = 1'b0;
      end else if (ramp_dist >= span) begin
        flat = 1'b1;
        full = 1'b1;
      end
    end

    ctl_nxt.valid = in_take;
    ctl_nxt.flat  = flat;
    ctl_nxt.full  = full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r   <= ctl_nxt;
      rem_r   <= ramp_dist[VALUE_WIDTH-1:0];
      width_r <= span[VALUE_WIDTH-1:0];
    end
  end

  assign ctl_o   = ctl_r;
  assign rem_o   = rem_r;
  assign width_o = width_r;
  assign quo_o   = '0;

  a_ramp_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.valid && !ctl_r.flat) |-> (width_r != '0 && rem_r < width_r))
    else $error("front stage passed a ramp with an unusable width");

endmodule

>>> design/fme_div_cell.sv
// ----------------------------------------------------------------------------
// Fuzzy membership divider cell
// One restoring division step: doubles the partial remainder, subtracts the
// ramp width when it fits and shifts one quotient bit in.
// ----------------------------------------------------------------------------
module fme_div_cell #(
  parameter int VALUE_WIDTH   = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  fme_pkg::stage_ctl_t      ctl_i,
  input  logic [VALUE_WIDTH-1:0]   rem_i,
  input  logic [VALUE_WIDTH-1:0]   width_i,
  input  logic [FRACTION_BITS-1:0] quo_i,
  output fme_pkg::stage_ctl_t      ctl_o,
  output logic [VALUE_WIDTH-1:0]   rem_o,
  output logic [VALUE_WIDTH-1:0]   width_o,
  output logic [FRACTION_BITS-1:0] quo_o
);
  import fme_pkg::*;

  logic [VALUE_WIDTH:0]     rem_dbl, rem_sub;
  logic                     fits;
  stage_ctl_t               ctl_r;
  logic [VALUE_WIDTH-1:0]   rem_r, rem_nxt, width_r;
  logic [FRACTION_BITS-1:0] quo_r, quo_nxt;

  assign rem_dbl = {rem_i, 1'b0};
  assign rem_sub = rem_dbl - {1'b0, width_i};
  assign fits    = (rem_dbl >= {1'b0, width_i});
  assign rem_nxt = fits ? rem_sub[VALUE_WIDTH-1:0] : rem_dbl[VALUE_WIDTH-1:0];
  assign quo_nxt = {quo_i[FRACTION_BITS-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r   <= ctl_i;
      rem_r   <= rem_nxt;
      width_r <= width_i;
      quo_r   <= quo_nxt;
    end
  end

  assign ctl_o   = ctl_r;
  assign rem_o   = rem_r;
  assign width_o = width_r;
  assign quo_o   = quo_r;

  a_rem_below_width: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.valid && !ctl_r.flat) |-> (rem_r < width_r))
    else $error("divider remainder reached the ramp width");

endmodule

>>> design/fuzzy_membership_evaluator.sv
// ----------------------------------------------------------------------------
// Fuzzy membership evaluator
// Returns the membership degree of a signed crisp value in a left shoulder,
// right shoulder, triangle or trapezoid shape given by four breakpoints.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                                Direction  Carries
//   input    in_valid, in_stall, in_crisp_value   in         one crisp value
//   result   out_valid, out_stall, out_degree     out        one degree, Q1.15
//   config   cfg_we, cfg_index, cfg_wdata         in         register writes
//
// One request enters per clock while the chain advances, and its degree
// passes through one front stage, one divider cell per quotient bit, and
// the output register, in that order.
// Reset clears every valid flag and loads the register reset values.
// The whole chain advances together; it holds only while the output
// register is full and stalled, and in_stall reports exactly that.
//
module fuzzy_membership_evaluator #(
  parameter int VALUE_WIDTH   = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [VALUE_WIDTH-1:0]           in_crisp_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [FRACTION_BITS:0]                  out_degree,
  input  logic                                    cfg_we,
  input  logic [fme_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [VALUE_WIDTH-1:0]                  cfg_wdata
);
  import fme_pkg::*;

  localparam logic [FRACTION_BITS:0] FULL_DEGREE = {1'b1, {FRACTION_BITS{1'b0}}};

  // Configuration registers.
  logic [1:0]                    shape_mode_r;
  logic signed [VALUE_WIDTH-1:0] first_point_r, second_point_r;
  logic signed [VALUE_WIDTH-1:0] third_point_r, last_point_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_mode_r   <= SHAPE_TRIANGLE;
      first_point_r  <= '0;
      second_point_r <= '0;
      third_point_r  <= '0;
      last_point_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHAPE_MODE:   shape_mode_r   <= cfg_wdata[1:0];
        CFG_FIRST_POINT:  first_point_r  <= cfg_wdata;
        CFG_SECOND_POINT: second_point_r <= cfg_wdata;
        CFG_THIRD_POINT:  third_point_r  <= cfg_wdata;
        CFG_LAST_POINT:   last_point_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The chain moves whenever the output register is empty or being taken.
  logic out_valid_r;
  logic advance;
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // Stage links: index 0 is the front stage, index i+1 is divider cell i.
  stage_ctl_t               ctl_s   [0:FRACTION_BITS];
  logic [VALUE_WIDTH-1:0]   rem_s   [0:FRACTION_BITS];
  logic [VALUE_WIDTH-1:0]   width_s [0:FRACTION_BITS];
  logic [FRACTION_BITS-1:0] quo_s   [0:FRACTION_BITS];

  fme_front #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (advance),
    .in_take      (in_valid),
    .crisp        (in_crisp_value),
    .shape_mode   (shape_mode_r),
    .first_point  (first_point_r),
    .second_point (second_point_r),
    .third_point  (third_point_r),
    .last_point   (last_point_r),
    .ctl_o        (ctl_s[0]),
    .rem_o        (rem_s[0]),
    .width_o      (width_s[0]),
    .quo_o        (quo_s[0])
  );

  // Each cell resolves one quotient bit, most significant first.
  for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_cell
    fme_div_cell #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (advance),
      .ctl_i   (ctl_s[i]),
      .rem_i   (rem_s[i]),
      .width_i (width_s[i]),
      .quo_i   (quo_s[i]),
      .ctl_o   (ctl_s[i+1]),
      .rem_o   (rem_s[i+1]),
      .width_o (width_s[i+1]),
      .quo_o   (quo_s[i+1])
    );
  end

  // Output register. A flat degree is zero or full; a ramp degree is the
  // quotient, which stays below full membership by construction.
  stage_ctl_t             last_ctl;
  logic [FRACTION_BITS:0] out_degree_r, degree_nxt;

  assign last_ctl = ctl_s[FRACTION_BITS];

  always_comb begin
    if (last_ctl.flat) begin
      degree_nxt = last_ctl.full ? FULL_DEGREE : '0;
    end else begin
      degree_nxt = {1'b0, quo_s[FRACTION_BITS]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r  <= last_ctl.valid;
      out_degree_r <= degree_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_degree = out_degree_r;

  a_degree_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_degree_r <= FULL_DEGREE))
    else $error("membership degree above full membership");

  a_chain_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && last_ctl.valid) |=> out_valid_r)
    else $error("request at the end of the chain was lost");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

endmodule
